// File: hdl/rocca_pkg.sv
// Package for the Rocca-S encryption engine: 128-bit word type, AES S-box,
// round constants and the single AES round function. No dependencies.
`default_nettype none
package rocca_pkg;

   typedef logic [127:0] word_type;

   localparam word_type Z0 = 128'hcd65ef2391443771_22ae28d7982f8a42;
   localparam word_type Z1 = 128'hbcdb8981a5dbb5e9_2f3b4deccffbc0b5;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_AD     = 2'd1;
   localparam logic [1:0] MODE_MSG    = 2'd2;
   localparam logic [1:0] MODE_FINISH = 2'd3;

   localparam logic KIND_CIPHER = 1'b0;
   localparam logic KIND_TAG    = 1'b1;

   localparam logic [1:0] REG_KEY_W0 = 2'd0;
   localparam logic [1:0] REG_KEY_W1 = 2'd1;
   localparam logic [1:0] REG_KEY_W2 = 2'd2;
   localparam logic [1:0] REG_KEY_W3 = 2'd3;

   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   function automatic logic [7:0] sbox(input logic [7:0] a);
      sbox = SBOX_TABLE[2047 - 8 * a -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte 0 is the most significant byte of the word.
   function automatic word_type aes_enc_round(input word_type s, input word_type k);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      word_type r;
      for (int i = 0; i < 16; i++) b[i] = s[127 - 8 * i -: 8];
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++) t[4 * c + j] = sbox(b[4 * ((c + j) % 4) + j]);
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
         x = a0 ^ a1 ^ a2 ^ a3;
         r[127 - 32 * c -: 8]       = a0 ^ x ^ xtime(a0 ^ a1);
         r[127 - 32 * c - 8 -: 8]   = a1 ^ x ^ xtime(a1 ^ a2);
         r[127 - 32 * c - 16 -: 8]  = a2 ^ x ^ xtime(a2 ^ a3);
         r[127 - 32 * c - 24 -: 8]  = a3 ^ x ^ xtime(a3 ^ a0);
      end
      aes_enc_round = r ^ k;
   endfunction

   function automatic logic [63:0] bswap64(input logic [63:0] v);
      for (int i = 0; i < 8; i++) bswap64[8 * i +: 8] = v[63 - 8 * i -: 8];
   endfunction

endpackage
`default_nettype wire

// File: hdl/rocca_round.sv
// Rocca-S round function datapath: one full state update per cycle.
// Depends on rocca_pkg for the AES round.
`default_nettype none
module rocca_round
   import rocca_pkg::*;
(
   input  wire word_type s_in [7],
   input  wire word_type x0,
   input  wire word_type x1,
   output word_type      s_out [7]
);
   assign s_out[0] = s_in[6] ^ s_in[1];
   assign s_out[1] = aes_enc_round(s_in[0], x0);
   assign s_out[2] = aes_enc_round(s_in[1], s_in[0]);
   assign s_out[3] = aes_enc_round(s_in[2], s_in[6]);
   assign s_out[4] = aes_enc_round(s_in[3], x1);
   assign s_out[5] = aes_enc_round(s_in[4], s_in[3]);
   assign s_out[6] = aes_enc_round(s_in[5], s_in[4]);
endmodule
`default_nettype wire

// File: hdl/rocca_s_aead_encrypt.sv
// Top level of the Rocca-S authenticated encryption engine.
// Depends on rocca_pkg and rocca_round.
`default_nettype none
// Rocca-S encryption engine with a 256-bit key held in four 64-bit
// registers written through the csr_ port; the user must write them only
// while the engine is idle, which the engine does not enforce. Each
// request transaction carries a mode: start loads the nonce and runs
// INIT_FINAL_ROUNDS state updates then mixes in the key; associated data
// runs one update; message emits a ciphertext transaction and runs one
// update; finish runs INIT_FINAL_ROUNDS updates with the byte-reversed bit
// lengths and emits the tag. The shared round unit performs one full state
// update per cycle in ST_RUN and on each accepted AD or message request.
// After associated data a new request can be accepted in the next cycle;
// after a message, once its ciphertext response has left; after start,
// once acceptance, the rounds and the key mix are done; after finish, once
// the rounds, the tag register and the response handoff are done. While
// working, or while a response transaction waits behind rsp_stall,
// req_stall is high.
module rocca_s_aead_encrypt
   import rocca_pkg::*;
#(
   parameter int INIT_FINAL_ROUNDS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_data,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_mode,
   input  wire  [63:0] req_data_w0,
   input  wire  [63:0] req_data_w1,
   input  wire  [63:0] req_data_w2,
   input  wire  [63:0] req_data_w3,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_out_kind,
   output logic [63:0] rsp_out_w0,
   output logic [63:0] rsp_out_w1,
   output logic [63:0] rsp_out_w2,
   output logic [63:0] rsp_out_w3
);
   localparam int CW = $clog2(INIT_FINAL_ROUNDS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_MIX, ST_DONE} state_type;

   logic [63:0] key_ff [4];
   word_type    s_ff [7];
   word_type    s_in [7];
   word_type    s_upd [7];
   word_type    x0_ff, x1_ff, x0_in, x1_in;
   state_type   state_ff;
   logic [CW-1:0] cnt_ff;
   logic        mode_start_ff;
   logic        accept;
   word_type    k0, k1, l0, l1, c0, c1;

   assign k0 = {key_ff[0], key_ff[1]};
   assign k1 = {key_ff[2], key_ff[3]};
   assign l0 = {req_data_w0, req_data_w1};
   assign l1 = {req_data_w2, req_data_w3};
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid;

   // The round unit takes its inputs straight from the request for a
   // single-update transaction, otherwise from the held round inputs.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         x0_in = l0;
         x1_in = l1;
      end else begin
         x0_in = x0_ff;
         x1_in = x1_ff;
      end
      s_in = s_ff;
   end

   rocca_round u_round (.s_in(s_in), .x0(x0_in), .x1(x1_in), .s_out(s_upd));

   assign c0 = aes_enc_round(s_ff[3] ^ s_ff[5], s_ff[0]) ^ l0;
   assign c1 = aes_enc_round(s_ff[4] ^ s_ff[6], s_ff[2]) ^ l1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid <= 1'b0;
         cnt_ff <= '0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         for (int i = 0; i < 7; i++) s_ff[i] <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_KEY_W0: key_ff[0] <= csr_data;
               REG_KEY_W1: key_ff[1] <= csr_data;
               REG_KEY_W2: key_ff[2] <= csr_data;
               REG_KEY_W3: key_ff[3] <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_mode)
                     MODE_START: begin
                        s_ff[0] <= k1; s_ff[1] <= l0; s_ff[2] <= Z0; s_ff[3] <= k0;
                        s_ff[4] <= Z1; s_ff[5] <= l0 ^ k1; s_ff[6] <= '0;
                        x0_ff <= Z0; x1_ff <= Z1;
                        cnt_ff <= '0;
                        mode_start_ff <= 1'b1;
                        state_ff <= ST_RUN;
                     end
                     MODE_AD: s_ff <= s_upd;
                     MODE_MSG: begin
                        s_ff <= s_upd;
                        rsp_valid <= 1'b1;
                        rsp_out_kind <= KIND_CIPHER;
                        {rsp_out_w0, rsp_out_w1} <= c0;
                        {rsp_out_w2, rsp_out_w3} <= c1;
                     end
                     default: begin
                        x0_ff <= {bswap64(req_data_w0), 64'd0};
                        x1_ff <= {bswap64(req_data_w1), 64'd0};
                        cnt_ff <= '0;
                        mode_start_ff <= 1'b0;
                        state_ff <= ST_RUN;
                     end
                  endcase
               end
            end
            ST_RUN: begin
               s_ff <= s_upd;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(INIT_FINAL_ROUNDS - 1))
                  state_ff <= mode_start_ff ? ST_MIX : ST_DONE;
            end
            ST_MIX: begin
               s_ff[0] <= s_ff[0] ^ k0; s_ff[1] <= s_ff[1] ^ k0;
               s_ff[2] <= s_ff[2] ^ k1; s_ff[3] <= s_ff[3] ^ k0;
               s_ff[4] <= s_ff[4] ^ k0; s_ff[5] <= s_ff[5] ^ k1;
               s_ff[6] <= s_ff[6] ^ k1;
               state_ff <= ST_IDLE;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               rsp_out_kind <= KIND_TAG;
               {rsp_out_w0, rsp_out_w1} <= s_ff[0] ^ s_ff[1] ^ s_ff[2] ^ s_ff[3];
               {rsp_out_w2, rsp_out_w3} <= s_ff[4] ^ s_ff[5] ^ s_ff[6];
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: hdl/rocca_checker.sv
// Port-level checker for the Rocca-S engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rocca_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_out_kind,
   input wire [63:0] rsp_out_w0
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_w0) && $stable(rsp_out_kind))
      else $error("stalled response transaction changed");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall) || $past(req_valid))
      else $error("response transaction from nowhere");
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind rocca_s_aead_encrypt rocca_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_kind(rsp_out_kind),
   .rsp_out_w0(rsp_out_w0));
`default_nettype wire

// File: sim/rocca_s_aead_checker.sv
// Checker for the Rocca-S encryption engine: watches the key writes and both
// channels, predicts ciphertext and tag transactions, compares them.
// Depends on rocca_pkg for the word type, codes and constants.
module rocca_s_aead_checker
   import rocca_pkg::*;
#(
   parameter int ROUNDS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_data,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [1:0]  req_mode,
   input  wire  [63:0] req_data_w0,
   input  wire  [63:0] req_data_w1,
   input  wire  [63:0] req_data_w2,
   input  wire  [63:0] req_data_w3,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire         rsp_out_kind,
   input  wire  [63:0] rsp_out_w0,
   input  wire  [63:0] rsp_out_w1,
   input  wire  [63:0] rsp_out_w2,
   input  wire  [63:0] rsp_out_w3,
   output int          error_count,
   output int          pending_count,
   output int          rsp_count
);

   typedef struct packed {
      logic       kind;
      logic [255:0] data;
   } block_result_type;

   localparam logic [7:0] SB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   word_type         key_half0, key_half1;
   word_type         st [7];
   block_result_type expected_q [$];

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // One AES round with byte 0 as the most significant byte.
   function automatic word_type aes_step(input word_type s, input word_type k);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      word_type r;
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++)
            t[4*c+j] = SB[s[127 - 8*(4*((c+j)%4)+j) -: 8]];
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         x = a0 ^ a1 ^ a2 ^ a3;
         r[127-32*c -: 32] = {a0 ^ x ^ gmul2(a0 ^ a1), a1 ^ x ^ gmul2(a1 ^ a2),
                              a2 ^ x ^ gmul2(a2 ^ a3), a3 ^ x ^ gmul2(a3 ^ a0)};
      end
      return r ^ k;
   endfunction

   function automatic logic [63:0] reverse_bytes(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = v[63-8*i -: 8];
      return r;
   endfunction

   task automatic state_update(input word_type x0, input word_type x1);
      word_type n [7];
      n[0] = st[6] ^ st[1];
      n[1] = aes_step(st[0], x0);
      n[2] = aes_step(st[1], st[0]);
      n[3] = aes_step(st[2], st[6]);
      n[4] = aes_step(st[3], x1);
      n[5] = aes_step(st[4], st[3]);
      n[6] = aes_step(st[5], st[4]);
      st = n;
   endtask

   task automatic predict_block(input logic [1:0] mode, input word_type lane0,
                                input word_type lane1);
      block_result_type res;
      word_type la, lm;
      case (mode)
         MODE_START: begin
            st = '{key_half1, lane0, Z0, key_half0, Z1, lane0 ^ key_half1, '0};
            for (int i = 0; i < ROUNDS; i++) state_update(Z0, Z1);
            st[0] ^= key_half0; st[1] ^= key_half0; st[3] ^= key_half0;
            st[4] ^= key_half0; st[2] ^= key_half1; st[5] ^= key_half1;
            st[6] ^= key_half1;
         end
         MODE_AD: state_update(lane0, lane1);
         MODE_MSG: begin
            res.kind = KIND_CIPHER;
            res.data = {aes_step(st[3] ^ st[5], st[0]) ^ lane0,
                        aes_step(st[4] ^ st[6], st[2]) ^ lane1};
            expected_q.push_back(res);
            state_update(lane0, lane1);
         end
         default: begin
            la = {reverse_bytes(lane0[127:64]), 64'd0};
            lm = {reverse_bytes(lane0[63:0]), 64'd0};
            for (int i = 0; i < ROUNDS; i++) state_update(la, lm);
            res.kind = KIND_TAG;
            res.data = {st[0] ^ st[1] ^ st[2] ^ st[3], st[4] ^ st[5] ^ st[6]};
            expected_q.push_back(res);
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      block_result_type want;
      if (reset) begin
         key_half0 = '0; key_half1 = '0;
         foreach (st[i]) st[i] = '0;
         expected_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_KEY_W0: key_half0[127:64] = csr_data;
               REG_KEY_W1: key_half0[63:0]   = csr_data;
               REG_KEY_W2: key_half1[127:64] = csr_data;
               default:    key_half1[63:0]   = csr_data;
            endcase
         end
         if (req_valid && !req_stall)
            predict_block(req_mode, {req_data_w0, req_data_w1},
                          {req_data_w2, req_data_w3});
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_q.size() == 0) begin
               $error("unexpected response transaction, kind %0d", rsp_out_kind);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               compare_field("out_kind", 64'(want.kind), 64'(rsp_out_kind));
               compare_field("out_w0", want.data[255:192], rsp_out_w0);
               compare_field("out_w1", want.data[191:128], rsp_out_w1);
               compare_field("out_w2", want.data[127:64], rsp_out_w2);
               compare_field("out_w3", want.data[63:0], rsp_out_w3);
            end
         end
      end
      pending_count = expected_q.size();
   end

   initial begin
      error_count = 0;
      pending_count = 0;
      rsp_count = 0;
   end

endmodule

// File: sim/rocca_s_aead_encrypt_tb.sv
// Testbench top for the Rocca-S encryption engine: clock, reset, key writes,
// request traffic and response stalls; the checker does the comparison.
// Depends on rocca_pkg, rocca_s_aead_encrypt and rocca_s_aead_checker.
module rocca_s_aead_encrypt_tb;
   import rocca_pkg::*;

   localparam int ROUNDS      = 16;
   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE_WAIT = 2 * ROUNDS + 8;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [63:0] req_data_w0, req_data_w1, req_data_w2, req_data_w3;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_out_kind;
   logic [63:0] rsp_out_w0, rsp_out_w1, rsp_out_w2, rsp_out_w3;

   int error_count, pending_count, rsp_count;
   int req_count;
   int idle_cycles;
   // Set once by the stimulus to ask the response side for one long hold-off.
   logic hold_request;

   rocca_s_aead_encrypt #(.INIT_FINAL_ROUNDS(ROUNDS)) dut (.*);

   rocca_s_aead_checker #(.ROUNDS(ROUNDS)) u_check (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Often no gap at all, else mostly a short gap and now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Extremes show up often so every bit sees both values.
   function automatic logic [63:0] edge_value();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   // Drives one request transaction and waits until the engine takes it.
   task automatic send_block(input logic [1:0] mode, input logic [63:0] w0,
                             input logic [63:0] w1, input logic [63:0] w2,
                             input logic [63:0] w3);
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_data_w0 <= w0;
      req_data_w1 <= w1;
      req_data_w2 <= w2;
      req_data_w3 <= w3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_count++;
   endtask

   // Lowers valid for a random gap unless the next transaction follows at once.
   task automatic sender_gap();
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Waits until every expected transaction arrived and the engine is quiet,
   // since start and associated-data work produces no response.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
      logic [63:0] vals [4];
      vals = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         csr_index <= 2'(i);
         csr_data  <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // One well-formed message: start, some AD, some message blocks, finish.
   task automatic send_message(input int max_ad, input int max_msg);
      int n_ad, n_msg;
      n_ad  = $urandom_range(0, max_ad);
      n_msg = $urandom_range(0, max_msg);
      send_block(MODE_START, edge_value(), edge_value(), edge_value(), edge_value());
      sender_gap();
      repeat (n_ad) begin
         send_block(MODE_AD, edge_value(), edge_value(), edge_value(), edge_value());
         sender_gap();
      end
      repeat (n_msg) begin
         send_block(MODE_MSG, edge_value(), edge_value(), edge_value(), edge_value());
         sender_gap();
      end
      send_block(MODE_FINISH, 64'(n_ad) * 256, 64'(n_msg) * 256, rand64(), rand64());
      sender_gap();
   endtask

   // Response side, decided cycle by cycle: random stalls, plus one long
   // hold-off as soon as the stimulus asks for it.
   initial begin
      int left;
      bit hold_done;
      left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            left = 300;
         end else if (left > 0) begin
            left--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            left = $urandom_range(0, 7);
         end else if ($urandom_range(0, 3) != 0) begin
            left = gap_length();
            if (left > 0) rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      idle_cycles  = 0;
      req_count    = 0;
      hold_request = 1'b0;
      reset       <= 1'b1;
      csr_write   <= 1'b0;
      csr_index   <= REG_KEY_W0;
      csr_data    <= '0;
      req_valid   <= 1'b0;
      req_mode    <= MODE_START;
      req_data_w0 <= '0;
      req_data_w1 <= '0;
      req_data_w2 <= '0;
      req_data_w3 <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First run on the reset key of all zeros, with zero and
      // all-ones data, every mode, and items out of the usual order.
      send_block(MODE_MSG, '0, '0, '0, '0);
      send_block(MODE_FINISH, '0, '0, '1, '1);
      send_block(MODE_START, '0, '0, '0, '0);
      send_block(MODE_AD, '1, '1, '1, '1);
      send_block(MODE_MSG, '1, '1, '1, '1);
      send_block(MODE_FINISH, '1, '1, '0, '0);
      drain();
      write_key('1, '1, '1, '1);
      send_block(MODE_START, '1, '1, '1, '1);
      send_block(MODE_AD, '0, '0, '0, '0);
      send_block(MODE_MSG, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef,
                 64'hfedc_ba98_7654_3210, 64'h1);
      send_block(MODE_FINISH, 64'd256, 64'd200, '0, '0);
      send_block(MODE_START, 64'h0123_4567_89ab_cdef, '0, '0, '0);
      send_block(MODE_START, '0, '0, '0, '0);
      send_block(MODE_FINISH, 64'h1, 64'h8000_0000_0000_0000, '0, '0);
      drain();
      write_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f);
      send_message(2, 3);

      // The sender pauses until every response has arrived, then the response
      // side holds off a long time while messages keep coming so the engine
      // backs up into its request side.
      drain();
      hold_request = 1'b1;
      repeat (20) send_block(MODE_MSG, rand64(), rand64(), rand64(), rand64());
      send_block(MODE_FINISH, '0, 64'd5120, '0, '0);

      // Random part in phases with a fresh key each time.
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         write_key(edge_value(), edge_value(), edge_value(), edge_value());
         while (req_count < 300 * (phase + 1)) begin
            if ($urandom_range(0, 9) < 8)
               send_message(3, 6);
            else begin
               // Noise: any mode with random content in any order.
               send_block(2'($urandom_range(0, 3)), edge_value(), edge_value(),
                          edge_value(), edge_value());
               sender_gap();
            end
         end
      end

      drain();
      $display("Covered %0d request and %0d response transactions over 8 keys,",
               req_count, rsp_count);
      $display("well-formed messages, noise items and long response stalls.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
